// ===== hdl/smx_pkg.sv =====
// Shared types and constants of the stereo send/return mixer.
package smx_pkg;

  localparam int SAMPLE_BITS    = 24;
  localparam int GAIN_BITS      = 16;
  localparam int GAIN_FRAC_BITS = 15;
  localparam int PROD_BITS      = SAMPLE_BITS + GAIN_BITS + 1;
  localparam int SUM_BITS       = SAMPLE_BITS + 2;
  localparam int COUNT_BITS     = 32;
  localparam int CFG_IDX_BITS   = 2;

  localparam logic [GAIN_BITS-1:0] GAIN_UNITY =
    GAIN_BITS'((1 << GAIN_FRAC_BITS) - 1);

  localparam logic signed [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  localparam logic CMD_SEND = 1'b0;
  localparam logic CMD_MIX  = 1'b1;

  localparam logic [CFG_IDX_BITS-1:0] REG_REVERB_SEND_GAIN      = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CHORUS_TO_REVERB_GAIN = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_CHORUS_RETURN_GAIN    = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_REVERB_RETURN_GAIN    = 2'd3;

  typedef struct packed {
    logic [GAIN_BITS-1:0] reverb_send;
    logic [GAIN_BITS-1:0] chorus_to_reverb;
    logic [GAIN_BITS-1:0] chorus_return;
    logic [GAIN_BITS-1:0] reverb_return;
  } gains_t;

  typedef struct packed {
    logic                          cmd;
    logic                          commit;
    logic signed [SAMPLE_BITS-1:0] dry_left;
    logic signed [SAMPLE_BITS-1:0] dry_right;
    logic signed [SAMPLE_BITS-1:0] chorus_left;
    logic signed [SAMPLE_BITS-1:0] chorus_right;
    logic signed [SAMPLE_BITS-1:0] reverb_left;
    logic signed [SAMPLE_BITS-1:0] reverb_right;
  } frame_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] value;
    logic                          sat;
  } chan_res_t;

endpackage

// ===== hdl/smx_gain.sv =====
// Q1.15 gain stage: unity pass-through or floored scaled product.
module smx_gain import smx_pkg::*; (
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic        [GAIN_BITS-1:0]   gain_i,
  output logic signed [SAMPLE_BITS-1:0] scaled_o
);

  logic signed [PROD_BITS-1:0] prod;
  logic signed [PROD_BITS-1:0] shifted;

  always_comb begin
    prod     = PROD_BITS'(sample_i) * $signed(PROD_BITS'(gain_i));
    shifted  = prod >>> GAIN_FRAC_BITS;
    scaled_o = (gain_i >= GAIN_UNITY) ? sample_i : shifted[SAMPLE_BITS-1:0];
  end

endmodule

// ===== hdl/smx_channel.sv =====
// One channel of the mixer: gain stages, three-way sum and saturation.
module smx_channel import smx_pkg::*; (
  input  logic                          cmd_i,
  input  gains_t                        gains_i,
  input  logic signed [SAMPLE_BITS-1:0] dry_i,
  input  logic signed [SAMPLE_BITS-1:0] chorus_i,
  input  logic signed [SAMPLE_BITS-1:0] reverb_i,
  output chan_res_t                     res_o
);

  logic signed [SAMPLE_BITS-1:0] dry_scaled;
  logic signed [SAMPLE_BITS-1:0] chorus_scaled;
  logic signed [SAMPLE_BITS-1:0] reverb_scaled;
  logic        [GAIN_BITS-1:0]   chorus_gain;
  logic signed [SAMPLE_BITS-1:0] term_a;
  logic signed [SAMPLE_BITS-1:0] term_c;
  logic signed [SUM_BITS-1:0]    sum;

  assign chorus_gain = (cmd_i == CMD_MIX) ? gains_i.chorus_return : gains_i.chorus_to_reverb;

  smx_gain u_dry_gain (
    .sample_i (dry_i),
    .gain_i   (gains_i.reverb_send),
    .scaled_o (dry_scaled)
  );

  smx_gain u_chorus_gain (
    .sample_i (chorus_i),
    .gain_i   (chorus_gain),
    .scaled_o (chorus_scaled)
  );

  smx_gain u_reverb_gain (
    .sample_i (reverb_i),
    .gain_i   (gains_i.reverb_return),
    .scaled_o (reverb_scaled)
  );

  always_comb begin
    term_a = (cmd_i == CMD_MIX) ? dry_i : dry_scaled;
    term_c = (cmd_i == CMD_MIX) ? reverb_scaled : '0;
    sum    = SUM_BITS'(term_a) + SUM_BITS'(chorus_scaled) + SUM_BITS'(term_c);
    if (sum > SUM_BITS'(SAT_MAX)) begin
      res_o.value = SAT_MAX;
      res_o.sat   = 1'b1;
    end else if (sum < SUM_BITS'(SAT_MIN)) begin
      res_o.value = SAT_MIN;
      res_o.sat   = 1'b1;
    end else begin
      res_o.value = sum[SAMPLE_BITS-1:0];
      res_o.sat   = 1'b0;
    end
  end

endmodule

// ===== hdl/stereo_effect_send_return_mixer_top.sv =====
// Top level of the stereo effect send/return mixer with its gain registers and counters.
// The mixer accepts one stereo frame per clock cycle unless the output stalls. A frame is
// captured in an input register, passes through the gain multipliers, the three-way channel
// sum and the 24-bit clamp, and lands in the result register. A stalled output holds the
// result while the next frame waits in the input register. The saturation event count and
// the sticky gain flag shown with each result are the values after that frame. The user
// must write the gain registers through the configuration port only while no frame is in
// flight; the block itself does not enforce this.
module stereo_effect_send_return_mixer_top import smx_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]       cfg_idx_i,
  input  logic [GAIN_BITS-1:0]          cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          cmd_i,
  input  logic                          commit_i,
  input  logic signed [SAMPLE_BITS-1:0] dry_left_i,
  input  logic signed [SAMPLE_BITS-1:0] dry_right_i,
  input  logic signed [SAMPLE_BITS-1:0] chorus_left_i,
  input  logic signed [SAMPLE_BITS-1:0] chorus_right_i,
  input  logic signed [SAMPLE_BITS-1:0] reverb_left_i,
  input  logic signed [SAMPLE_BITS-1:0] reverb_right_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] out_left_o,
  output logic signed [SAMPLE_BITS-1:0] out_right_o,
  output logic                          sat_left_o,
  output logic                          sat_right_o,
  output logic [COUNT_BITS-1:0]         event_count_o,
  output logic                          gain_clamped_o
);

  gains_t                gains_q, gains_d;
  frame_t                frame_q;
  logic                  in_valid_q;
  logic                  out_valid_q;
  chan_res_t             res_left, res_right;
  chan_res_t             res_left_q, res_right_q;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic                  clamp_q, clamp_d;
  logic                  in_xfer;
  logic                  out_load;
  logic                  update;
  logic                  over;
  logic [1:0]            n_sat;
  logic [COUNT_BITS:0]   count_sum;

  assign out_load   = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || out_load;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    gains_d = gains_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_REVERB_SEND_GAIN:      gains_d.reverb_send      = cfg_data_i;
        REG_CHORUS_TO_REVERB_GAIN: gains_d.chorus_to_reverb = cfg_data_i;
        REG_CHORUS_RETURN_GAIN:    gains_d.chorus_return    = cfg_data_i;
        REG_REVERB_RETURN_GAIN:    gains_d.reverb_return    = cfg_data_i;
        default:                   gains_d = gains_q;
      endcase
    end
  end

  smx_channel u_left (
    .cmd_i    (frame_q.cmd),
    .gains_i  (gains_q),
    .dry_i    (frame_q.dry_left),
    .chorus_i (frame_q.chorus_left),
    .reverb_i (frame_q.reverb_left),
    .res_o    (res_left)
  );

  smx_channel u_right (
    .cmd_i    (frame_q.cmd),
    .gains_i  (gains_q),
    .dry_i    (frame_q.dry_right),
    .chorus_i (frame_q.chorus_right),
    .reverb_i (frame_q.reverb_right),
    .res_o    (res_right)
  );

  always_comb begin
    if (frame_q.cmd == CMD_MIX) begin
      over   = (gains_q.chorus_return > GAIN_UNITY) || (gains_q.reverb_return > GAIN_UNITY);
      update = 1'b1;
    end else begin
      over   = (gains_q.reverb_send > GAIN_UNITY) || (gains_q.chorus_to_reverb > GAIN_UNITY);
      update = frame_q.commit;
    end
    n_sat     = 2'(res_left.sat) + 2'(res_right.sat);
    count_sum = (COUNT_BITS+1)'(count_q) + (COUNT_BITS+1)'(n_sat);
    count_d   = count_q;
    clamp_d   = clamp_q;
    if (out_load && update) begin
      count_d = count_sum[COUNT_BITS] ? '1 : count_sum[COUNT_BITS-1:0];
      clamp_d = clamp_q || over;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains_q     <= '0;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
      clamp_q     <= 1'b0;
    end else begin
      gains_q     <= gains_d;
      count_q     <= count_d;
      clamp_q     <= clamp_d;
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      frame_q <= '{cmd:          cmd_i,
                   commit:       commit_i,
                   dry_left:     dry_left_i,
                   dry_right:    dry_right_i,
                   chorus_left:  chorus_left_i,
                   chorus_right: chorus_right_i,
                   reverb_left:  reverb_left_i,
                   reverb_right: reverb_right_i};
    end
    if (out_load) begin
      res_left_q  <= res_left;
      res_right_q <= res_right;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_left_o     = res_left_q.value;
  assign out_right_o    = res_right_q.value;
  assign sat_left_o     = res_left_q.sat;
  assign sat_right_o    = res_right_q.sat;
  assign event_count_o  = count_q;
  assign gain_clamped_o = clamp_q;

  a_count_monotonic : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q >= $past(count_q))
    else $error("Saturation event count decreased.");

  a_count_only_on_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(out_load) |-> $stable(count_q))
    else $error("Saturation event count changed without a result being loaded.");

  a_clamp_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(clamp_q) |-> clamp_q)
    else $error("Gain clamp flag was cleared.");

  a_sat_left_value : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && sat_left_o) |-> (out_left_o == SAT_MAX || out_left_o == SAT_MIN))
    else $error("Left channel flagged as saturated but not at a rail.");

endmodule
